/* rtl/core/sst_pkg.sv */
// shared types and constants for the sorted set table
package sst_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int INDEX_W      = 4;
    localparam int COUNT_W      = 5;

    // operation codes carried in a command word
    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    // command word
    typedef struct packed {
        mode_t                      mode;
        logic signed [VALUE_W-1:0]  value;
        logic [INDEX_W-1:0]         index;
    } cmd_t;

    // result word
    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  read_value;
        logic [COUNT_W-1:0]         count;
        logic                       is_empty;
    } result_t;

    // broadcast from the control to every cell
    typedef struct packed {
        logic                       do_insert;
        logic                       do_delete;
        logic signed [VALUE_W-1:0]  value;
    } cell_ctl_t;

endpackage

/* rtl/core/sst_cell.sv */
// one storage cell of the sorted chain: holds an entry and shifts with its neighbors
module sst_cell (
    input  logic                                clk,
    input  sst_pkg::cell_ctl_t                  ctl,
    input  logic                                occupied,
    input  logic                                left_thr,
    input  logic signed [sst_pkg::VALUE_W-1:0]  left_entry,
    input  logic signed [sst_pkg::VALUE_W-1:0]  right_entry,
    output logic                                thr,
    output logic                                hit,
    output logic signed [sst_pkg::VALUE_W-1:0]  entry
);

    logic signed [sst_pkg::VALUE_W-1:0] entry_reg;
    logic signed [sst_pkg::VALUE_W-1:0] entry_next;
    logic                               le;

    // compare the broadcast value against the held entry
    assign le    = (ctl.value <= entry_reg);
    assign thr   = !occupied || le;
    assign hit   = occupied && (ctl.value == entry_reg);
    assign entry = entry_reg;

    // insert shifts up from the left, delete pulls down from the right
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.do_insert)
        begin
            if (left_thr)
                entry_next = left_entry;
            else if (thr)
                entry_next = ctl.value;
        end
        else if (ctl.do_delete && occupied && le)
        begin
            entry_next = right_entry;
        end
    end

    // entry storage, undefined until written
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* rtl/core/sorted_set_table.sv */
// Sorted set table: holds up to CAPACITY distinct signed 32-bit values in ascending order
// in a row of cells, one entry per cell. Every cell compares the command value against
// its entry at once, so insert, delete, search and read never stall:
// busy stays low, a command is taken on every clock with start high, and its result
// appears with done high for exactly one cycle on the next clock. The receiver cannot
// stall; a result not taken in that cycle is lost. The compare, the found reduction over
// all cells and the shift selection form one combinational path. Insert on a full table
// reports status 2, a duplicate, absent value or read at or past the count reports 1.
module sorted_set_table #(
    parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sst_pkg::cmd_t     cmd,
    output logic              done,
    output sst_pkg::result_t  result
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               done_reg;
    sst_pkg::result_t                   res_reg;
    sst_pkg::result_t                   res_next;

    logic [CAPACITY-1:0]                occ;
    logic [CAPACITY-1:0]                thr;
    logic [CAPACITY-1:0]                hit;
    logic signed [sst_pkg::VALUE_W-1:0] entry [CAPACITY];
    sst_pkg::cell_ctl_t                 ctl;

    logic                               accept;
    logic                               found;
    logic                               full;
    logic                               idx_ok;
    logic [ADDR_W-1:0]                  rd_addr;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign found  = |hit;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign idx_ok = (CNT_W'(cmd.index) < count_reg) && (cmd.index < CAPACITY);
    assign rd_addr = ADDR_W'(cmd.index);

    // broadcast control to the cells
    always_comb
    begin
        ctl.value     = cmd.value;
        ctl.do_insert = accept && (cmd.mode == sst_pkg::MODE_INSERT) && !full && !found;
        ctl.do_delete = accept && (cmd.mode == sst_pkg::MODE_DELETE) && found;
    end

    // chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                               l_thr;
        logic signed [sst_pkg::VALUE_W-1:0] l_entry;
        logic signed [sst_pkg::VALUE_W-1:0] r_entry;

        assign occ[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign l_thr   = 1'b0;
            assign l_entry = cmd.value;
        end
        else
        begin : g_mid
            assign l_thr   = thr[i-1];
            assign l_entry = entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign r_entry = entry[i];
        end
        else
        begin : g_inner
            assign r_entry = entry[i+1];
        end

        sst_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (occ[i]),
            .left_thr    (l_thr),
            .left_entry  (l_entry),
            .right_entry (r_entry),
            .thr         (thr[i]),
            .hit         (hit[i]),
            .entry       (entry[i])
        );
    end

    // count update and result word
    always_comb
    begin
        count_next = count_reg;
        if (ctl.do_insert)
            count_next = count_reg + CNT_W'(1);
        else if (ctl.do_delete)
            count_next = count_reg - CNT_W'(1);

        res_next.read_value = '0;
        res_next.status     = sst_pkg::STATUS_OK;
        unique case (cmd.mode)
            sst_pkg::MODE_INSERT:
            begin
                if (full)
                    res_next.status = sst_pkg::STATUS_FULL;
                else if (found)
                    res_next.status = sst_pkg::STATUS_MISS;
            end
            sst_pkg::MODE_DELETE, sst_pkg::MODE_SEARCH:
            begin
                if (!found)
                    res_next.status = sst_pkg::STATUS_MISS;
            end
            sst_pkg::MODE_READ:
            begin
                if (idx_ok)
                    res_next.read_value = entry[rd_addr];
                else
                    res_next.status = sst_pkg::STATUS_MISS;
            end
            default:
            begin
                res_next.status = sst_pkg::STATUS_MISS;
            end
        endcase
        res_next.count    = sst_pkg::COUNT_W'(count_next);
        res_next.is_empty = (count_next == '0);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= accept ? count_next : count_reg;
            done_reg  <= accept;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* rtl/core/sst_checker.sv */
// port-level checks for the sorted set table, bound to the top level
module sst_checker #(
    parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input sst_pkg::result_t  result
);

    // each accepted command gives exactly one result on the next clock
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted command without result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without command");

    // a full report only comes with the table at capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == sst_pkg::STATUS_FULL) |->
            (result.count == sst_pkg::COUNT_W'(CAPACITY)))
        else $error("full status with count below capacity");

    // failed operations never return data
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != sst_pkg::STATUS_OK) |-> (result.read_value == '0))
        else $error("read data on a failed operation");

    // an empty set reports count zero
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_empty) |-> (result.count == '0))
        else $error("empty flag with nonzero count");

endmodule

bind sorted_set_table sst_checker #(.CAPACITY(CAPACITY)) u_sst_checker (.*);
